/* rtl/pcm_sample_format_converter_top_assert.svh */
// Assertion macros for the PCM sample format converter
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSFC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PSFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PSFC_ASSERT_IMPL(label, ante, cons)
`define PSFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/psfc_pkg.sv */
//------------------------------------------------------------------------------
// psfc_pkg
// Format codes and shared types of the PCM sample format converter.
//------------------------------------------------------------------------------
`default_nettype none
package psfc_pkg;
	typedef enum logic [2:0] {
		FMT_S8  = 3'd0,
		FMT_U8  = 3'd1,
		FMT_S16 = 3'd2,
		FMT_U16 = 3'd3,
		FMT_S32 = 3'd4,
		FMT_U32 = 3'd5,
		FMT_FLT = 3'd6,
		FMT_DBL = 3'd7
	} fmt_t;

	typedef enum logic [0:0] {
		CFG_SOURCE = 1'b0,
		CFG_TARGET = 1'b1
	} cfg_idx_t;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned RESULT_W = 64;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 3;

	typedef struct packed {
		logic [RESULT_W-1:0] sample;
		logic                status;
	} result_t;
endpackage
`default_nettype wire

/* rtl/pcm_sample_format_converter_top.sv */
// One sample per transaction, held first in the input register and then in the
// result register; a new sample is taken every cycle while the output is
// drained or free. The user must set source and target formats through the
// configuration channel only while idle; the block does not enforce this.
//------------------------------------------------------------------------------
// pcm_sample_format_converter_top
// PCM sample format converter with valid/ready channels.
//------------------------------------------------------------------------------
`default_nettype none
`include "pcm_sample_format_converter_top_assert.svh"
module pcm_sample_format_converter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [psfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [psfc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [psfc_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [psfc_pkg::RESULT_W-1:0]       sample_out,
	output logic                                status
);
	import psfc_pkg::*;

	fmt_t src_q, dst_q;
	logic v_s1, v_s2;
	logic [SAMPLE_W-1:0] x_s1;
	result_t res, res_s2;
	logic adv_s2, adv_s1;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= FMT_S8;
			dst_q <= FMT_S8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SOURCE: src_q <= fmt_t'(cfg_data);
				CFG_TARGET: dst_q <= fmt_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// advance when the next stage is free or drains
	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// hold payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) x_s1 <= sample_in;
		if (adv_s2 && v_s1) res_s2 <= res;
	end

	psfc_convert u_conv (
		.src(src_q),
		.dst(dst_q),
		.x  (x_s1),
		.res(res)
	);

	assign out_valid = v_s2;
	assign sample_out = res_s2.sample;
	assign status = res_s2.status;

	`PSFC_ASSERT_IMPL(a_unsup_zero, out_valid && status, sample_out == 64'd0)
	`PSFC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(sample_out))
	`PSFC_ASSERT_IMPL(a_ready_free, !out_valid, in_ready)
endmodule
`default_nettype wire

/* rtl/psfc_convert.sv */
//------------------------------------------------------------------------------
// psfc_convert
// Combinational conversion of one sample between two formats.
//------------------------------------------------------------------------------
`default_nettype none
module psfc_convert (
	input  wire psfc_pkg::fmt_t          src,
	input  wire psfc_pkg::fmt_t          dst,
	input  wire logic [31:0]             x,
	output psfc_pkg::result_t            res
);
	import psfc_pkg::*;

	logic [7:0]  sb;          // signed byte
	logic [7:0]  ob;          // offset byte
	logic [63:0] byte_res;
	logic        byte_ok;
	logic [31:0] flt_b;       // byte to single
	logic [63:0] dbl_b;       // byte to double
	logic [31:0] flt_h;       // s16 to single
	logic [15:0] f2s;         // single to s16
	logic [7:0]  mag8;
	logic [2:0]  lz8;
	logic [15:0] mag16;
	logic [3:0]  lz16;
	logic [14:0] m16n;
	logic [7:0]  e;
	logic [23:0] mant;
	logic [39:0] shv;
	logic [15:0] ti;
	logic [63:0] r;
	logic        ok;

	// sign and magnitude of the byte value, leading one position
	always_comb begin
		sb = (src == FMT_U8) ? (x[7:0] ^ 8'h80) : x[7:0];
		ob = sb ^ 8'h80;
		mag8 = sb[7] ? (8'd0 - sb) : sb;
		lz8 = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (mag8[i]) lz8 = 3'(i);
		end
	end

	// byte value / 128 as single and double
	always_comb begin
		logic [7:0] nm;
		nm = mag8 << (3'd7 - lz8);
		if (mag8 == 8'd0) begin
			flt_b = 32'd0;
			dbl_b = 64'd0;
		end else begin
			flt_b = {sb[7], 8'(8'd120 + {5'd0, lz8}), nm[6:0], 16'd0};
			dbl_b = {sb[7], 11'(11'd1016 + {8'd0, lz8}), nm[6:0], 45'd0};
		end
	end

	// s16 value / 32768 as single
	always_comb begin
		logic [15:0] nm;
		mag16 = x[15] ? (16'd0 - x[15:0]) : x[15:0];
		lz16 = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag16[i]) lz16 = 4'(i);
		end
		nm = mag16 << (4'd15 - lz16);
		m16n = nm[14:0];
		if (mag16 == 16'd0) flt_h = 32'd0;
		else flt_h = {x[15], 8'(8'd112 + {4'd0, lz16}), m16n, 8'd0};
	end

	// single to s16: truncate toward zero, saturate, NaN to zero
	always_comb begin
		e = x[30:23];
		mant = {1'b1, x[22:0]};
		shv = 40'd0;
		ti = 16'd0;
		if (e == 8'hFF && x[22:0] != 23'd0) begin
			f2s = 16'd0;
		end else if (e >= 8'd127) begin
			// magnitude of at least 1.0 reaches a rail
			f2s = x[31] ? 16'h8000 : 16'h7FFF;
		end else begin
			// value*32768 = mant * 2^(e-150+15); integer part = mant >> (135-e)
			if (e >= 8'd112) shv = {16'd0, mant} >> (8'd135 - e);
			ti = shv[15:0];
			if (x[31]) f2s = 16'd0 - ti;
			else f2s = (ti[15]) ? 16'h7FFF : ti;
		end
	end

	// byte source to any target
	always_comb begin
		byte_ok = 1'b1;
		case (dst)
			FMT_S8:  byte_res = {56'd0, sb};
			FMT_U8:  byte_res = {56'd0, ob};
			FMT_S16: byte_res = {48'd0, sb, 8'd0};
			FMT_U16: byte_res = {48'd0, ob, 8'd0};
			FMT_S32: byte_res = {32'd0, sb, 24'd0};
			FMT_U32: byte_res = {32'd0, ob, 24'd0};
			FMT_FLT: byte_res = {32'd0, flt_b};
			FMT_DBL: byte_res = dbl_b;
			default: begin
				byte_res = 64'd0;
				byte_ok = 1'b0;
			end
		endcase
	end

	// select the path for the format pair
	always_comb begin
		r = 64'd0;
		ok = 1'b0;
		if (src == dst) begin
			ok = 1'b1;
			case (src)
				FMT_S8, FMT_U8:   r = {56'd0, x[7:0]};
				FMT_S16, FMT_U16: r = {48'd0, x[15:0]};
				default:          r = {32'd0, x};
			endcase
		end else if (src == FMT_S8 || src == FMT_U8) begin
			r = byte_res;
			ok = byte_ok;
		end else if (src == FMT_S16 && dst == FMT_S32) begin
			r = {32'd0, x[15:0], 16'd0};
			ok = 1'b1;
		end else if (src == FMT_S16 && dst == FMT_FLT) begin
			r = {32'd0, flt_h};
			ok = 1'b1;
		end else if (src == FMT_S32 && dst == FMT_S16) begin
			r = {48'd0, x[31:16]};
			ok = 1'b1;
		end else if (src == FMT_FLT && dst == FMT_S16) begin
			r = {48'd0, f2s};
			ok = 1'b1;
		end
		res.sample = ok ? r : 64'd0;
		res.status = ~ok;
	end
endmodule
`default_nettype wire

/* test/tb_pcm_sample_format_converter_top.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_pcm_sample_format_converter_top
// Self-checking bench for the PCM sample format converter. Source and target
// formats are programmed through the config channel, and samples are streamed
// under random idling and back-pressure. Each result is checked against a
// bit-exact conversion model kept in the bench.
//------------------------------------------------------------------------------
module tb_pcm_sample_format_converter_top;
	import psfc_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [RESULT_W-1:0]   sample_out;
	logic                  status;

	fmt_t    cur_src;
	fmt_t    cur_dst;
	result_t pending_q[$];
	int      mismatches;
	int      checked;
	int      cycles;
	int      rx_wait;
	int      rx_hold;
	bit      quiet;
	bit      pair_seen [8][8];

	pcm_sample_format_converter_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.status     (status)
	);

	// Clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Bail out on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Exact float encoding of v * 2^-k; dbl selects IEEE double
	function automatic logic [63:0] scaled_to_float(int v, int k, bit dbl);
		int          mag;
		int          msb;
		logic [63:0] frac;
		logic [63:0] bits;
		mag = (v < 0) ? -v : v;
		if (mag == 0)
			return 64'd0;
		msb = 0;
		for (int i = 0; i < 31; i++)
			if (mag[i])
				msb = i;
		frac = 64'(mag);
		if (dbl) begin
			frac = (frac << (52 - msb)) & 64'h000F_FFFF_FFFF_FFFF;
			bits = {(v < 0), 11'(msb - k + 1023), frac[51:0]};
		end else begin
			frac = (frac << (23 - msb)) & 64'h0000_0000_007F_FFFF;
			bits = {32'd0, (v < 0), 8'(msb - k + 127), frac[22:0]};
		end
		return bits;
	endfunction

	// Single to s16: scale by 32768, truncate toward zero, saturate, NaN to 0
	function automatic logic [15:0] single_to_pcm16(logic [31:0] b);
		int          ex;
		logic [23:0] man;
		int          mag;
		ex = int'(b[30:23]);
		man = {1'b1, b[22:0]};
		if (ex == 255 && b[22:0] != 23'd0)
			return 16'd0;
		if (ex >= 127)
			return b[31] ? 16'h8000 : 16'h7FFF;
		if (ex == 0 || ex < 112)
			return 16'd0;
		mag = int'(man >> (135 - ex));
		return b[31] ? 16'(-mag) : 16'(mag);
	endfunction

	// Byte value (already signed) to any target format
	function automatic result_t byte_to_format(int v, fmt_t dst);
		result_t r;
		logic [31:0] sv;
		logic [31:0] off;
		sv = 32'(v);
		off = 32'(v + 128);
		r.status = 1'b0;
		case (dst)
			FMT_S8:  r.sample = {56'd0, sv[7:0]};
			FMT_U8:  r.sample = {56'd0, off[7:0]};
			FMT_S16: r.sample = {48'd0, sv[7:0], 8'd0};
			FMT_U16: r.sample = {48'd0, off[7:0], 8'd0};
			FMT_S32: r.sample = {32'd0, sv[7:0], 24'd0};
			FMT_U32: r.sample = {32'd0, off[7:0], 24'd0};
			FMT_FLT: r.sample = scaled_to_float(v, 7, 1'b0);
			default: r.sample = scaled_to_float(v, 7, 1'b1);
		endcase
		return r;
	endfunction

	// Expected result of one sample under the current formats
	function automatic result_t convert_sample(fmt_t src, fmt_t dst, logic [31:0] x);
		result_t r;
		r.sample = '0;
		r.status = 1'b1;
		if (src == dst) begin
			r.status = 1'b0;
			case (src)
				FMT_S8, FMT_U8:   r.sample = {56'd0, x[7:0]};
				FMT_S16, FMT_U16: r.sample = {48'd0, x[15:0]};
				default:          r.sample = {32'd0, x};
			endcase
		end else if (src == FMT_S8) begin
			r = byte_to_format(int'($signed(x[7:0])), dst);
		end else if (src == FMT_U8) begin
			r = byte_to_format(int'(x[7:0]) - 128, dst);
		end else if (src == FMT_S16 && dst == FMT_S32) begin
			r.sample = {32'd0, x[15:0], 16'd0};
			r.status = 1'b0;
		end else if (src == FMT_S16 && dst == FMT_FLT) begin
			r.sample = scaled_to_float(int'($signed(x[15:0])), 15, 1'b0);
			r.status = 1'b0;
		end else if (src == FMT_S32 && dst == FMT_S16) begin
			r.sample = {48'd0, x[31:16]};
			r.status = 1'b0;
		end else if (src == FMT_FLT && dst == FMT_S16) begin
			r.sample = {48'd0, single_to_pcm16(x)};
			r.status = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h (src %s dst %s)", what, got, want,
			cur_src.name(), cur_dst.name());
		mismatches++;
	endtask

	// Receiver: random stalls, long hold-offs, and the result check
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result", sample_out, 64'd0);
				end else begin
					want = pending_q.pop_front();
					if (sample_out !== want.sample)
						report_mismatch("sample_out", sample_out, want.sample);
					if (status !== want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
					checked++;
				end
				rx_wait = quiet ? 0 : $urandom_range(0, 11);
			end else if (rx_wait > 0) begin
				rx_wait = rx_wait - 1;
			end
			if (rx_hold > 0)
				rx_hold = rx_hold - 1;
			out_ready <= (rx_wait == 0 && rx_hold == 0);
		end
	end

	// Send one sample; valid stays up afterwards unless the next call idles
	task automatic send_sample(logic [31:0] x);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(convert_sample(cur_src, cur_dst, x));
		pair_seen[cur_src][cur_dst] = 1'b1;
	endtask

	// Stop sending and let every expected result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, fmt_t val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SOURCE)
			cur_src = val;
		else
			cur_dst = val;
	endtask

	task automatic set_formats(fmt_t src, fmt_t dst);
		write_register(CFG_SOURCE, src);
		write_register(CFG_TARGET, dst);
	endtask

	// Sample shaped for the source format
	function automatic logic [31:0] pick_sample(fmt_t src);
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 9))
			0: x = 32'h0000_0000;
			1: x = 32'hFFFF_FFFF;
			2: x = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0} | x[7:0];
			default: ;
		endcase
		if (src == FMT_FLT) begin
			// Often the interesting exponent band, some NaN, infinity and zero exponent
			case ($urandom_range(0, 7))
				0: x[30:23] = 8'hFF;
				1: x[30:23] = 8'd0;
				2, 3, 4: x[30:23] = 8'($urandom_range(108, 130));
				default: ;
			endcase
		end
		return x;
	endfunction

	// Reset values: s8 to s8 passes through
	task automatic test_reset_formats();
		send_sample(32'hFFFF_FF80);
		send_sample(32'h1234_567F);
		send_sample(32'h0000_0000);
	endtask

	// Field extremes, several conversion paths, float special cases
	task automatic test_directed();
		set_formats(FMT_S8, FMT_DBL);
		send_sample(32'h0000_0080);
		send_sample(32'hFFFF_FF7F);
		set_formats(FMT_U8, FMT_FLT);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_00FF);
		send_sample(32'h0000_0080);
		set_formats(FMT_S16, FMT_FLT);
		send_sample(32'h0000_8000);
		send_sample(32'hFFFF_7FFF);
		send_sample(32'h0000_0001);
		set_formats(FMT_S32, FMT_S16);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		set_formats(FMT_FLT, FMT_S16);
		send_sample(32'h3F80_0000);   // +1.0 saturates high
		send_sample(32'hBF80_0000);   // -1.0 hits the low rail
		send_sample(32'h7FC0_0001);   // NaN gives zero
		send_sample(32'hFF80_0000);   // -infinity
		send_sample(32'h7F80_0000);   // +infinity
		send_sample(32'hBF7F_FFFF);   // just above -1.0, truncates
		send_sample(32'h0000_0001);   // denormal
		send_sample(32'h3800_0000);   // exactly one LSB
		set_formats(FMT_DBL, FMT_DBL);
		send_sample(32'hFFFF_FFFF);
		set_formats(FMT_U32, FMT_S8);
		send_sample(32'hFFFF_FFFF);
	endtask

	// Random format pairs, weighted toward the supported ones
	task automatic test_random_pairs(int phases, int per_phase);
		fmt_t src;
		fmt_t dst;
		for (int p = 0; p < phases; p++) begin
			src = fmt_t'($urandom_range(0, 7));
			dst = fmt_t'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 6))
					0, 1, 2: src = fmt_t'($urandom_range(0, 1));
					3: begin src = FMT_S16; dst = $urandom_range(0, 1) ? FMT_S32 : FMT_FLT; end
					4: begin src = FMT_S32; dst = FMT_S16; end
					5: begin src = FMT_FLT; dst = FMT_S16; end
					default: dst = src;
				endcase
			end
			set_formats(src, dst);
			quiet = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < per_phase; i++)
				send_sample(pick_sample(cur_src));
			quiet = 1'b0;
		end
	endtask

	// Hold the receiver off so the block fills and stalls its input
	task automatic test_backpressure();
		set_formats(FMT_FLT, FMT_S16);
		rx_hold = 200;
		quiet = 1'b1;
		for (int i = 0; i < 30; i++)
			send_sample(pick_sample(cur_src));
		quiet = 1'b0;
		drain_results();
		for (int i = 0; i < 20; i++)
			send_sample(pick_sample(cur_src));
	endtask

	initial begin
		int pairs;
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SOURCE;
		cfg_data <= FMT_S8;
		in_valid <= 1'b0;
		sample_in <= '0;
		cur_src = FMT_S8;
		cur_dst = FMT_S8;
		mismatches = 0;
		checked = 0;
		rx_hold = 0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_formats();
		test_directed();
		test_backpressure();
		test_random_pairs(45, 15);

		drain_results();
		repeat (10) @(posedge clk);
		pairs = 0;
		foreach (pair_seen[s, d])
			if (pair_seen[s][d])
				pairs++;
		$display("checked %0d samples over %0d of 64 format pairs, %0d mismatches",
			checked, pairs, mismatches);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* pcm_sample_format_converter_top.f */
+incdir+rtl
rtl/psfc_pkg.sv
rtl/psfc_convert.sv
rtl/pcm_sample_format_converter_top.sv
test/tb_pcm_sample_format_converter_top.sv
